// ===== hdl/stip_pkg.sv =====
`timescale 1ns / 1ps

package stip_pkg;

  // Offset limit: smaller of the character limit and the 8-bit offset range
  localparam int unsigned MaxChars    = 255;
  localparam int unsigned OffsetLimit = (MaxChars < 255) ? MaxChars : 255;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;

  localparam logic [4:0] BaseAuto = 5'd0;
  localparam logic [4:0] BaseOct  = 5'd8;
  localparam logic [4:0] BaseDec  = 5'd10;
  localparam logic [4:0] BaseHex  = 5'd16;
  localparam logic [4:0] NoDigit  = 5'd16;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  end_offset;
  } result_t;

  // Digit value of a character, NoDigit when it is none
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c >= ChZero && c <= ChNine) begin
      diff = c - ChZero;
      return diff[4:0];
    end else if (c >= ChLowA && c <= ChLowF) begin
      diff = c - ChLowA + 8'd10;
      return diff[4:0];
    end else if (c >= ChUpA && c <= ChUpF) begin
      diff = c - ChUpA + 8'd10;
      return diff[4:0];
    end
    return NoDigit;
  endfunction

endpackage

// ===== hdl/string_to_integer_parser.sv =====
`timescale 1ns / 1ps

// Streaming signed integer parser, one character per input beat.
// Input channel: in_valid_i / in_stall_o with character_i and last_i. A string
// ends at a NUL character or at a beat with last_i set; that beat yields one
// output beat, other beats yield none.
// Output channel: out_valid_o / out_stall_i with value_o (signed 64-bit,
// wrapping) and end_offset_o (characters consumed, saturating at 255).
// cfg_we_i / cfg_wdata_i set the radix (0 = detect 0x / 0 / decimal prefix);
// write it only while no string is in flight.
// A terminating beat waits in the input register, and the character step logic
// then writes its result into the output register. Throughput is one
// character per cycle while the receiver does not stall; the accumulate step
// (64-bit value times radix plus digit) is combinational.
// Reset clears the radix to 0, the parse state and the valid bits of both registers.
// While the receiver stalls with a result waiting, the character step holds
// and in_stall_o rises once the input register is full.

module string_to_integer_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         character_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] value_o,
  output logic [7:0]         end_offset_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i
);

  logic              in_valid_q;
  logic [7:0]        char_q;
  logic              last_q;
  logic [4:0]        base_q;
  logic              out_valid_q;
  stip_pkg::result_t res_q;
  stip_pkg::result_t step_res;
  logic              step_emit;
  logic              blocked;
  logic              step_en;

  assign blocked    = out_valid_q && out_stall_i;
  assign step_en    = in_valid_q && !blocked;
  assign in_stall_o = in_valid_q && blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 5'd0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= character_i;
      last_q <= last_i;
    end
  end

  stip_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (step_en),
    .character_i   (char_q),
    .last_i        (last_q),
    .number_base_i (base_q),
    .emit_o        (step_emit),
    .result_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_emit) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = signed'(res_q.value);
  assign end_offset_o = res_q.end_offset;

endmodule

// ===== hdl/stip_core.sv =====
`timescale 1ns / 1ps

module stip_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [7:0]         character_i,
  input  logic               last_i,
  input  logic [4:0]         number_base_i,
  output logic               emit_o,
  output stip_pkg::result_t  result_o
);

  typedef enum logic [2:0] {
    PhLead    = 3'd0,
    PhPrefix  = 3'd1,
    PhZero0   = 3'd2,
    PhZero16  = 3'd3,
    PhDigits  = 3'd4,
    PhStopped = 3'd5
  } phase_e;

  localparam logic [7:0] PosLimit = 8'(stip_pkg::OffsetLimit);

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [4:0]  base_q, base_d;
  logic [63:0] acc_q, acc_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  stop_q, stop_d;

  logic        do_prefix, do_zero, run_digits, emit;
  logic [4:0]  digit;
  logic [7:0]  pos_adv;
  logic [63:0] value;
  logic [7:0]  offset;

  assign pos_adv = (pos_q < PosLimit) ? pos_q + 8'd1 : pos_q;
  assign digit   = stip_pkg::digit_of(character_i);

  always_comb begin
    phase_d    = phase_q;
    neg_d      = neg_q;
    base_d     = base_q;
    acc_d      = acc_q;
    pos_d      = pos_q;
    stop_d     = stop_q;
    do_prefix  = 1'b0;
    do_zero    = 1'b0;
    run_digits = 1'b0;

    unique case (phase_q)
      PhLead: begin
        if (character_i == stip_pkg::ChSpace || character_i == stip_pkg::ChTab) begin
          pos_d = pos_adv;
        end else if (character_i == stip_pkg::ChMinus ||
                     character_i == stip_pkg::ChPlus) begin
          neg_d   = (character_i == stip_pkg::ChMinus);
          pos_d   = pos_adv;
          phase_d = PhPrefix;
        end else begin
          do_prefix = 1'b1;
        end
      end
      PhPrefix: do_prefix = 1'b1;
      PhZero0, PhZero16: do_zero = 1'b1;
      PhDigits: run_digits = 1'b1;
      default: ;
    endcase

    // Fix the radix at the first byte after the sign; in auto mode a leading 0 defers it to the byte after
    if (do_prefix) begin
      if (number_base_i == stip_pkg::BaseAuto) begin
        if (character_i == stip_pkg::ChZero) begin
          pos_d   = pos_adv;
          phase_d = PhZero0;
        end else begin
          base_d     = stip_pkg::BaseDec;
          run_digits = 1'b1;
        end
      end else if (number_base_i == stip_pkg::BaseHex) begin
        base_d = stip_pkg::BaseHex;
        if (character_i == stip_pkg::ChZero) begin
          pos_d   = pos_adv;
          phase_d = PhZero16;
        end else begin
          run_digits = 1'b1;
        end
      end else begin
        base_d     = number_base_i;
        run_digits = 1'b1;
      end
    end

    if (do_zero) begin
      if (character_i == stip_pkg::ChLowX || character_i == stip_pkg::ChUpX) begin
        base_d  = stip_pkg::BaseHex;
        pos_d   = pos_adv;
        phase_d = PhDigits;
      end else begin
        if (phase_q == PhZero0) base_d = stip_pkg::BaseOct;
        run_digits = 1'b1;
      end
    end

    if (run_digits) begin
      phase_d = PhDigits;
      if (digit < stip_pkg::NoDigit && digit < base_d) begin
        acc_d = acc_q * {59'd0, base_d} + {59'd0, digit};
        pos_d = pos_adv;
      end else begin
        stop_d  = pos_q;
        phase_d = PhStopped;
      end
    end
  end

  assign emit   = en_i && (character_i == stip_pkg::ChNul || last_i);
  assign offset = (phase_d == PhStopped) ? stop_d : pos_d;
  assign value  = neg_d ? (64'd0 - acc_d) : acc_d;

  assign emit_o              = emit;
  assign result_o.value      = value;
  assign result_o.end_offset = offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      neg_q   <= 1'b0;
      base_q  <= 5'd0;
      acc_q   <= 64'd0;
      pos_q   <= 8'd0;
      stop_q  <= 8'd0;
    end else if (emit) begin
      // string done: drop back to the start state
      phase_q <= PhLead;
      neg_q   <= 1'b0;
      base_q  <= 5'd0;
      acc_q   <= 64'd0;
      pos_q   <= 8'd0;
      stop_q  <= 8'd0;
    end else if (en_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      stop_q  <= stop_d;
    end
  end

endmodule
